// ----- src/array_list_insert_remove_unit_macros.svh -----
// Assertion helpers for the array list unit.
`ifndef ARRAY_LIST_INSERT_REMOVE_UNIT_MACROS_SVH
`define ARRAY_LIST_INSERT_REMOVE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ALIST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("alist check failed");

// The consequent must hold in the cycle after the antecedent.
`define ALIST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("alist check failed");

`else

`define ALIST_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ALIST_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/alist_pkg.sv -----
package alist_pkg;

    // Width of a cell position; covers every capacity up to 1024 and any
    // 8-bit requested position.
    localparam int IDX_W = 11;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_END   = 3'd4,
        OP_REM_AT    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  position;
        logic [31:0] entry_in;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] entry_out;
        logic [7:0]  count;
    } t_rsp;

    // Broadcast to every cell on an accepted request.
    typedef struct packed {
        logic             load;
        logic             shift_up;
        logic             shift_down;
        logic             pick;
        logic [IDX_W-1:0] at;
    } t_cell_cmd;

    // Number of eight-way OR levels needed to reduce n leaves to one.
    function automatic int tree_levels(int n);
        int lv;
        int span;
        lv = 1;
        span = 8;
        while (span < n) begin
            span = span * 8;
            lv = lv + 1;
        end
        return lv;
    endfunction

endpackage

// ----- src/alist_cell.sv -----
module alist_cell
    import alist_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int INDEX = 0
) (
    input  logic             i_clk,
    input  t_cell_cmd        i_cmd,
    input  logic [WIDTH-1:0] i_word,
    input  logic [WIDTH-1:0] i_left,
    input  logic [WIDTH-1:0] i_right,
    output logic [WIDTH-1:0] o_data,
    output logic [WIDTH-1:0] o_pick
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] r_pick;

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_up) begin
            if (MY_IDX > i_cmd.at) begin
                r_data <= i_left;
            end else if (MY_IDX == i_cmd.at) begin
                r_data <= i_word;
            end
        end else if (i_cmd.shift_down && (MY_IDX >= i_cmd.at)) begin
            r_data <= i_right;
        end
    end

    // The old contents are captured before the shift so the tree sees them.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pick <= (i_cmd.pick && (MY_IDX == i_cmd.at)) ? r_data : '0;
        end
    end

    assign o_data = r_data;
    assign o_pick = r_pick;

endmodule

// ----- src/alist_or_tree.sv -----
module alist_or_tree
    import alist_pkg::*;
#(
    parameter int N     = 128,
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_leaf [N],
    output logic [WIDTH-1:0] o_result
);

    localparam int LV = tree_levels(N);

    logic [WIDTH-1:0] r_lvl [LV][N];

    for (genvar l = 1; l <= LV; l++) begin : g_lvl
        localparam int NI = (N + (1 << (3 * (l - 1))) - 1) >> (3 * (l - 1));
        localparam int NO = (NI + 7) >> 3;
        localparam int SRC = (l > 1) ? (l - 2) : 0;
        for (genvar j = 0; j < NO; j++) begin : g_node
            always_ff @(posedge i_clk) begin
                logic [WIDTH-1:0] v;
                v = '0;
                for (int k = 0; k < 8; k++) begin
                    if (j * 8 + k < NI) begin
                        if (l == 1) begin
                            v = v | i_leaf[j * 8 + k];
                        end else begin
                            v = v | r_lvl[SRC][j * 8 + k];
                        end
                    end
                end
                r_lvl[l - 1][j] <= v;
            end
        end
    end

    assign o_result = r_lvl[LV - 1][0];

endmodule

// ----- src/array_list_insert_remove_unit.sv -----
// Bounded array list held in a row of CAPACITY cells, one entry word per
// cell. A successful insert or removal shifts the cells at once: inserts
// move the entries at and after the insert point up one place, removals
// move the entries after the removed one down. The removed word is
// gathered by a registered eight-way OR tree of LEVELS =
// ceil(log8(CAPACITY)) levels (three for 128 entries). A response is
// ready once the pick registers and every tree level are loaded, and a
// new request is taken in the cycle that response moves into the output
// register, so requests do not overlap in the tree. The output register
// lets the next request start while a response waits to be taken. The
// returned count field is the low eight bits of the entry count.
`include "array_list_insert_remove_unit_macros.svh"

module array_list_insert_remove_unit
    import alist_pkg::*;
#(
    parameter int CAPACITY    = 128,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int LEVELS = tree_levels(CAPACITY);
    localparam int WW     = $clog2(LEVELS + 1);

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_pend;
    logic [WW-1:0]   r_wait;
    t_status         r_pend_status;
    logic            r_out_valid;
    t_rsp            r_out_rsp;

    logic             w_fire;
    logic             w_out_load;
    logic [IDX_W-1:0] w_cnt;
    logic [IDX_W-1:0] w_pos;
    logic             w_full;
    logic             w_empty;
    logic             w_ins_ok;
    logic             w_rem_ok;
    t_status          w_status;
    t_cell_cmd        w_cmd;
    logic [ENTRY_WIDTH-1:0] w_word;
    logic [ENTRY_WIDTH-1:0] w_data [CAPACITY];
    logic [ENTRY_WIDTH-1:0] w_pick [CAPACITY];
    logic [ENTRY_WIDTH-1:0] w_removed;

    assign w_out_load = r_pend && (r_wait == '0) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && !w_out_load;
    assign w_fire     = i_in_valid && !o_in_stall;

    assign w_cnt   = IDX_W'(r_count);
    assign w_pos   = IDX_W'(i_in_req.position);
    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_word  = ENTRY_WIDTH'(i_in_req.entry_in);

    always_comb begin
        w_cmd    = '0;
        w_ins_ok = 1'b0;
        w_rem_ok = 1'b0;
        w_status = ST_OK;
        unique case (i_in_req.operation)
            OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
                unique case (i_in_req.operation)
                    OP_INS_FRONT: w_cmd.at = '0;
                    OP_INS_END:   w_cmd.at = w_cnt;
                    default:      w_cmd.at = w_pos;
                endcase
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_cmd.at > w_cnt) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_ins_ok = 1'b1;
                end
            end
            OP_REM_FRONT, OP_REM_END, OP_REM_AT: begin
                unique case (i_in_req.operation)
                    OP_REM_FRONT: w_cmd.at = '0;
                    OP_REM_END:   w_cmd.at = w_cnt - IDX_W'(1);
                    default:      w_cmd.at = w_pos;
                endcase
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_cmd.at >= w_cnt) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_rem_ok = 1'b1;
                end
            end
            default: begin
                // Unused operation codes leave the list alone.
                w_status = ST_OK;
            end
        endcase
        w_cmd.load       = w_fire;
        w_cmd.shift_up   = w_fire && w_ins_ok;
        w_cmd.shift_down = w_fire && w_rem_ok;
        w_cmd.pick       = w_rem_ok;
    end

    always_comb begin
        n_count = r_count;
        if (w_fire && w_ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_fire && w_rem_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ENTRY_WIDTH-1:0] w_left;
        logic [ENTRY_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_word;
        end else begin : g_mid_l
            assign w_left = w_data[g - 1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_word;
        end else begin : g_mid_r
            assign w_right = w_data[g + 1];
        end
        alist_cell #(
            .WIDTH (ENTRY_WIDTH),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_word  (w_word),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_pick  (w_pick[g])
        );
    end

    alist_or_tree #(
        .N     (CAPACITY),
        .WIDTH (ENTRY_WIDTH)
    ) u_tree (
        .i_clk    (i_clk),
        .i_leaf   (w_pick),
        .o_result (w_removed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_pend <= 1'b1;
                r_wait <= WW'(LEVELS);
            end else begin
                if (w_out_load) begin
                    r_pend <= 1'b0;
                end
                if (r_wait != '0) begin
                    r_wait <= r_wait - WW'(1);
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_pend_status <= w_status;
        end
        if (w_out_load) begin
            r_out_rsp.status    <= r_pend_status;
            r_out_rsp.entry_out <= 32'(w_removed);
            r_out_rsp.count     <= 8'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    `ALIST_ASSERT_NEXT(a_fire_pends, i_clk, i_rst_n, w_fire, r_pend)
    `ALIST_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `ALIST_ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n, w_fire && w_ins_ok,
        r_count == $past(r_count) + CW'(1))
    `ALIST_ASSERT_NEXT(a_fail_no_word, i_clk, i_rst_n, w_out_load && (r_pend_status != ST_OK),
        r_out_rsp.entry_out == '0)

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import alist_pkg::*;

    localparam int LIST_CAP = 128;

    // The block ignores these two operation codes.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Shadow copy of the list. It predicts the response to every accepted
    // request and holds those responses until the block returns them.
    class alist_shadow;
        logic [31:0] cells [LIST_CAP];
        int unsigned held;
        t_rsp        pending_rsp [$];
        int unsigned fail_count;

        function new();
            held = 0;
            fail_count = 0;
        endfunction

        function t_status insert_at(int unsigned at, logic [31:0] word);
            if (held >= LIST_CAP) return ST_FULL;
            if (at > held) return ST_BADPOS;
            for (int unsigned i = held; i > at; i--) cells[i] = cells[i - 1];
            cells[at] = word;
            held++;
            return ST_OK;
        endfunction

        function t_status remove_at(int unsigned at, output logic [31:0] word);
            word = '0;
            if (held == 0) return ST_EMPTY;
            if (at >= held) return ST_BADPOS;
            word = cells[at];
            for (int unsigned i = at; i + 1 < held; i++) cells[i] = cells[i + 1];
            held--;
            return ST_OK;
        endfunction

        function void take_request(t_req req);
            t_rsp        rsp;
            logic [31:0] word;
            rsp = '0;
            word = '0;
            case (req.operation)
                OP_INS_FRONT: rsp.status = insert_at(0, req.entry_in);
                OP_INS_END:   rsp.status = insert_at(held, req.entry_in);
                OP_INS_AT:    rsp.status = insert_at(req.position, req.entry_in);
                OP_REM_FRONT: rsp.status = remove_at(0, word);
                OP_REM_END:   rsp.status = remove_at((held == 0) ? 0 : held - 1, word);
                OP_REM_AT:    rsp.status = remove_at(req.position, word);
                default:      rsp.status = ST_OK;
            endcase
            rsp.entry_out = word;
            rsp.count = held[7:0];
            pending_rsp.push_back(rsp);
        endfunction

        function void match_response(t_rsp got);
            t_rsp want;
            if (pending_rsp.size() == 0) begin
                $display("%0t: response %h arrived with no request outstanding", $time, got);
                fail_count++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                fail_count++;
            end
            if (got.entry_out !== want.entry_out) begin
                $display("%0t: entry_out expected %h, got %h", $time, want.entry_out,
                         got.entry_out);
                fail_count++;
            end
            if (got.count !== want.count) begin
                $display("%0t: count expected %0d, got %0d", $time, want.count, got.count);
                fail_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_req i_in_req;
    logic o_out_valid;
    logic i_out_stall;
    t_rsp o_out_rsp;

    alist_shadow shadow;
    int          send_idle_pct;
    int          stall_pct;

    array_list_insert_remove_unit #(
        .CAPACITY    (LIST_CAP),
        .ENTRY_WIDTH (32)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) shadow.take_request(i_in_req);
        if (i_rst_n && o_out_valid && !i_out_stall) shadow.match_response(o_out_rsp);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_req(t_req req);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= req;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_op(logic [2:0] op, logic [7:0] pos, logic [31:0] word);
        t_req req;
        req.operation = op;
        req.position = pos;
        req.entry_in = word;
        send_req(req);
    endtask

    // Mostly well-formed requests: positions usually fall inside the list.
    function automatic t_req random_req(int ins_pct);
        t_req        req;
        int unsigned top;
        req.position = 8'($urandom_range(0, 255));
        req.entry_in = $urandom;
        if ($urandom_range(0, 99) < 4)
            req.operation = ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
        else if ($urandom_range(0, 99) < ins_pct)
            req.operation = 3'($urandom_range(OP_INS_FRONT, OP_INS_AT));
        else
            req.operation = 3'($urandom_range(OP_REM_FRONT, OP_REM_AT));
        if ($urandom_range(0, 99) < 75) begin
            top = shadow.held;
            if (req.operation == OP_INS_AT)
                req.position = 8'($urandom_range(0, top));
            else if (req.operation == OP_REM_AT)
                req.position = 8'($urandom_range(0, (top == 0) ? 0 : top - 1));
        end
        return req;
    endfunction

    task automatic fill_list();
        int extra;
        extra = 0;
        while (extra < 12) begin
            if (shadow.held == LIST_CAP) extra++;
            send_req(random_req(95));
        end
    endtask

    task automatic drain_list();
        int extra;
        extra = 0;
        while (extra < 12) begin
            if (shadow.held == 0) extra++;
            send_req(random_req(5));
        end
    endtask

    task automatic directed_reqs();
        send_op(OP_REM_FRONT, 8'd0, 32'hFFFF_FFFF);
        send_op(OP_REM_END, 8'd0, 32'd0);
        send_op(OP_REM_AT, 8'd0, 32'd0);
        send_op(OP_REM_AT, 8'd255, 32'd0);
        send_op(OP_SPARE_6, 8'd0, 32'd0);
        send_op(OP_SPARE_7, 8'd255, 32'hFFFF_FFFF);
        send_op(OP_INS_AT, 8'd1, 32'h1111_1111);
        send_op(OP_INS_AT, 8'd255, 32'h2222_2222);
        send_op(OP_INS_AT, 8'd0, 32'h0000_0000);
        send_op(OP_INS_END, 8'd0, 32'hFFFF_FFFF);
        send_op(OP_INS_FRONT, 8'd0, 32'hA5A5_A5A5);
        send_op(OP_INS_AT, 8'd3, 32'h5A5A_5A5A);
        send_op(OP_INS_AT, 8'd2, 32'h1234_5678);
        send_op(OP_INS_AT, 8'd6, 32'h3333_3333);
        send_op(OP_REM_AT, 8'd5, 32'd0);
        send_op(OP_REM_AT, 8'd128, 32'd0);
        send_op(OP_REM_AT, 8'd4, 32'd0);
        send_op(OP_REM_AT, 8'd1, 32'd0);
        send_op(OP_REM_END, 8'd0, 32'd0);
        send_op(OP_REM_FRONT, 8'd0, 32'd0);
        send_op(OP_REM_FRONT, 8'd0, 32'd0);
        // The count must stay at zero when the end is removed from an empty list.
        send_op(OP_REM_END, 8'd0, 32'd0);
        send_op(OP_SPARE_6, 8'd255, 32'hFFFF_FFFF);
    endtask

    initial begin
        int send_plan [4];
        int stall_plan [4];
        send_plan = '{0, 50, 0, 36};
        stall_plan = '{0, 0, 50, 36};
        shadow = new();
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_req = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_plan[ph];
            stall_pct = stall_plan[ph];
            if (ph == 0) directed_reqs();
            fill_list();
            drain_list();
            repeat (30) send_req(random_req(50));
        end
        i_in_valid <= 1'b0;
        while (shadow.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (shadow.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/alist_pkg.sv
src/alist_cell.sv
src/alist_or_tree.sv
src/array_list_insert_remove_unit.sv
bench/tb_top.sv
